// ===== sv/tbs_pkg.sv =====
package tbs_pkg;

  // fixed field widths
  localparam int unsigned SAMPLE_W  = 20;
  localparam int unsigned POS_W     = 9;
  localparam int unsigned HW_W      = 6;
  localparam int unsigned SUM_W     = 29;
  localparam int unsigned DIV_W     = 7;
  localparam int unsigned RING_AW   = 7;
  localparam int unsigned RING_DEPTH = 1 << RING_AW;
  localparam int unsigned CFG_AW    = 3;
  localparam int unsigned CFG_DW    = 9;

  // register reset values
  localparam logic [POS_W-1:0] LOW_BOUND_RST  = 9'd0;
  localparam logic [POS_W-1:0] HIGH_BOUND_RST = 9'd511;
  localparam logic [POS_W-1:0] LEFT_EDGE_RST  = 9'd192;
  localparam logic [POS_W-1:0] RIGHT_EDGE_RST = 9'd320;
  localparam logic [HW_W-1:0]  HALF_WIDTH_RST = 6'd16;

  typedef enum logic [CFG_AW-1:0] {
    REG_LOW_BOUND  = 3'd0,
    REG_HIGH_BOUND = 3'd1,
    REG_LEFT_EDGE  = 3'd2,
    REG_RIGHT_EDGE = 3'd3,
    REG_HALF_WIDTH = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_ZONE,
    S_RD_HI,
    S_RD_LO,
    S_DIFF,
    S_DIV,
    S_OUT
  } state_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_value;
    logic                       sample_last;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] smoothed_value;
    logic [POS_W-1:0]           out_index;
    logic                       out_last;
  } out_word_t;

  typedef struct packed {
    logic [POS_W-1:0] low_bound;
    logic [POS_W-1:0] high_bound;
    logic [POS_W-1:0] left_edge;
    logic [POS_W-1:0] right_edge;
    logic [HW_W-1:0]  half_width;
  } cfg_t;

  // box half-width for one index; pass means copy the sample through
  typedef struct packed {
    logic            pass;
    logic [HW_W-1:0] h;
  } zone_t;

endpackage

// ===== sv/tbs_ram.sv =====
module tbs_ram (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [tbs_pkg::RING_AW-1:0] waddr_i,
  input  logic [tbs_pkg::SUM_W-1:0]   wdata_i,
  input  logic [tbs_pkg::RING_AW-1:0] raddr_i,
  output logic [tbs_pkg::SUM_W-1:0]   rdata_o
);
  import tbs_pkg::*;

  logic [SUM_W-1:0] mem [RING_DEPTH];
  logic [SUM_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/tbs_div.sv =====
module tbs_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [tbs_pkg::SUM_W-1:0] dividend_i,
  input  logic [tbs_pkg::DIV_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [tbs_pkg::SUM_W-1:0] quotient_o
);
  import tbs_pkg::*;

  localparam int unsigned CNT_W = $clog2(SUM_W + 1);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [SUM_W-1:0] quo_q, quo_d;
  logic [DIV_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] div_q, div_d;
  logic [DIV_W:0]   rem_sh;
  logic             fits;

  // one quotient bit a cycle, restoring
  assign rem_sh = {rem_q, quo_q[SUM_W-1]};
  assign fits   = rem_sh >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(SUM_W);
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        cnt_d = cnt_q - 1'b1;
        quo_d = {quo_q[SUM_W-2:0], fits};
        rem_d = fits ? DIV_W'(rem_sh - {1'b0, div_q}) : rem_sh[DIV_W-1:0];
      end else begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o     = busy_q && (cnt_q == '0);
  assign quotient_o = quo_q;

endmodule

// ===== sv/tbs_zone.sv =====
module tbs_zone #(
  parameter int unsigned SAMPLES        = 512,
  parameter int unsigned MAX_HALF_WIDTH = 32
) (
  input  logic [$clog2(SAMPLES+1)-1:0] idx_i,
  input  tbs_pkg::cfg_t                cfg_i,
  output tbs_pkg::zone_t               zone_o
);
  import tbs_pkg::*;

  localparam int unsigned CNT_W = $clog2(SAMPLES + 1);
  localparam int unsigned IDX_W = ((CNT_W > POS_W + 1) ? CNT_W : POS_W + 1) + 2;
  localparam logic [HW_W-1:0] MaxW = HW_W'(MAX_HALF_WIDTH);

  logic [HW_W-1:0]         w;
  logic signed [IDX_W-1:0] i_s, w_s, lo_s, hi_s, le_s, re_s;
  logic signed [IDX_W-1:0] le_far, re_far, hi_lim, a_left, b_right, a_right, end_right;
  logic signed [IDX_W-1:0] dl, dr;
  logic [HW_W-1:0]         h;

  assign w    = (cfg_i.half_width > MaxW) ? MaxW : cfg_i.half_width;
  assign i_s  = $signed({{(IDX_W-CNT_W){1'b0}}, idx_i});
  assign w_s  = $signed({{(IDX_W-HW_W){1'b0}}, w});
  assign lo_s = $signed({{(IDX_W-POS_W){1'b0}}, cfg_i.low_bound});
  assign hi_s = $signed({{(IDX_W-POS_W){1'b0}}, cfg_i.high_bound});
  assign le_s = $signed({{(IDX_W-POS_W){1'b0}}, cfg_i.left_edge});
  assign re_s = $signed({{(IDX_W-POS_W){1'b0}}, cfg_i.right_edge});

  assign le_far    = le_s - (w_s <<< 1);
  assign re_far    = re_s + (w_s <<< 1);
  assign hi_lim    = hi_s - w_s - IDX_W'(1);
  assign a_left    = (lo_s + w_s > le_far) ? lo_s + w_s : le_far;
  assign b_right   = (re_far - IDX_W'(1) < hi_lim) ? re_far - IDX_W'(1) : hi_lim;
  assign a_right   = (re_far < hi_lim) ? re_far : hi_lim;
  assign end_right = $signed(IDX_W'(SAMPLES)) - w_s - IDX_W'(1);
  assign dl        = le_s - i_s;
  assign dr        = i_s - re_s;

  // later zone wins
  always_comb begin
    h = '0;
    if (i_s >= a_left && i_s < le_s) begin
      h = HW_W'(dl[IDX_W-1:1]) + 1'b1;
    end
    if (i_s <= b_right && i_s > re_s) begin
      h = HW_W'(dr[IDX_W-1:1]) + 1'b1;
    end
    if (i_s >= w_s + IDX_W'(1) && i_s < le_far) begin
      h = w;
    end
    if (i_s >= a_right && i_s < end_right) begin
      h = w;
    end
  end

  assign zone_o.h    = h;
  assign zone_o.pass = (w == '0) || (h == '0);

endmodule

// ===== sv/tapered_box_smoother.sv =====
// Tapered box smoother: box mean over x[i-h..i+h] from a 128-entry prefix-sum ring.
// Latency: result i leaves after word i+33 is taken (or on the last word, which flushes).
// Flow: words are taken only while idle, once the results they release are all out; a
//   mean waits on the 29-step divider, a pass-through skips it; a last word emits up to 34.
// Reset: async active low; config to defaults, counters and running sum to zero.
//   The prefix ring is not cleared; no clearing pass.
module tapered_box_smoother #(
  parameter int unsigned SAMPLES        = 512,
  parameter int unsigned MAX_HALF_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // sample words in
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  tbs_pkg::in_word_t            in_data_i,
  // result words out
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output tbs_pkg::out_word_t           out_data_o,
  // config write port
  input  logic                         cfg_we_i,
  input  logic [tbs_pkg::CFG_AW-1:0]   cfg_addr_i,
  input  logic [tbs_pkg::CFG_DW-1:0]   cfg_wdata_i
);
  import tbs_pkg::*;

  localparam int unsigned CNT_W = $clog2(SAMPLES + 1);
  localparam int unsigned IDX_W = ((CNT_W > POS_W + 1) ? CNT_W : POS_W + 1) + 2;
  localparam int unsigned LAG   = MAX_HALF_WIDTH + 1;
  localparam logic [CNT_W:0] LagC     = (CNT_W + 1)'(LAG);
  localparam logic [CNT_W:0] SamplesC = (CNT_W + 1)'(SAMPLES);

  state_e state_q, state_d;

  // config registers
  cfg_t cfg_q;

  // stream state
  logic [SUM_W-1:0] sum_q;
  logic [CNT_W-1:0] in_cnt_q;
  logic [CNT_W-1:0] out_cnt_q;
  logic             last_q;

  // per-result datapath
  logic signed [IDX_W-1:0] hi_idx_q, lo_idx_q;
  logic [HW_W-1:0]         h_q;
  logic                    pass_q;
  logic [SUM_W-1:0]        hi_val_q;
  logic                    neg_q;
  out_word_t               out_q;

  logic             in_fire, out_fire;
  logic             emit_more;
  logic [SUM_W-1:0] new_sum;
  logic             in_last;
  zone_t            zone;
  logic [HW_W-1:0]  h_eff;
  logic signed [IDX_W-1:0] i_s, cnt_s;
  logic [RING_AW-1:0] ram_raddr;
  logic [SUM_W-1:0] ram_rdata;
  logic [SUM_W-1:0] hi_val, lo_val, diff, mag;
  logic             div_start, div_done;
  logic [SUM_W-1:0] quo, quo_neg;
  logic             res_last;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;

  // running prefix sum, mod 2^29
  assign new_sum = sum_q + SUM_W'(in_data_i.sample_value);
  assign in_last = in_data_i.sample_last || (({1'b0, in_cnt_q} + 1'b1) >= SamplesC);

  assign emit_more = (out_cnt_q < in_cnt_q) &&
                     (last_q || (({1'b0, out_cnt_q} + LagC) < {1'b0, in_cnt_q}));

  assign res_last = last_q && (({1'b0, out_cnt_q} + 1'b1) == {1'b0, in_cnt_q});

  tbs_zone #(
    .SAMPLES        (SAMPLES),
    .MAX_HALF_WIDTH (MAX_HALF_WIDTH)
  ) u_zone (
    .idx_i  (out_cnt_q),
    .cfg_i  (cfg_q),
    .zone_o (zone)
  );

  assign i_s   = $signed({{(IDX_W-CNT_W){1'b0}}, out_cnt_q});
  assign cnt_s = $signed({{(IDX_W-CNT_W){1'b0}}, in_cnt_q});
  assign h_eff = zone.pass ? '0 : zone.h;

  tbs_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (in_fire),
    .waddr_i (in_cnt_q[RING_AW-1:0]),
    .wdata_i (new_sum),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // below index 0 reads zero; beyond what was received reads the final sum
  always_comb begin
    if (hi_idx_q < 0) begin
      hi_val = '0;
    end else if (hi_idx_q >= cnt_s) begin
      hi_val = sum_q;
    end else begin
      hi_val = ram_rdata;
    end
    if (lo_idx_q < 0) begin
      lo_val = '0;
    end else if (lo_idx_q >= cnt_s) begin
      lo_val = sum_q;
    end else begin
      lo_val = ram_rdata;
    end
  end

  assign diff = hi_val_q - lo_val;
  assign mag  = diff[SUM_W-1] ? SUM_W'(-diff) : diff;

  // rounding: (|s| + h) / (2h+1), sign put back afterwards
  tbs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag + SUM_W'(h_q)),
    .divisor_i  ({h_q, 1'b1}),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  assign quo_neg = SUM_W'(-quo);

  // sequencer: next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_fire) state_d = S_CHECK;
      S_CHECK: state_d = emit_more ? S_ZONE : S_IDLE;
      S_ZONE:  state_d = S_RD_HI;
      S_RD_HI: state_d = S_RD_LO;
      S_RD_LO: state_d = S_DIFF;
      S_DIFF:  state_d = pass_q ? S_OUT : S_DIV;
      S_DIV:   if (div_done) state_d = S_OUT;
      S_OUT:   if (out_ready_i) state_d = S_CHECK;
      default: state_d = S_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    div_start   = 1'b0;
    ram_raddr   = hi_idx_q[RING_AW-1:0];
    unique case (state_q)
      S_IDLE:  in_ready_o  = 1'b1;
      S_RD_LO: ram_raddr   = lo_idx_q[RING_AW-1:0];
      S_DIFF:  div_start   = !pass_q;
      S_OUT:   out_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_bound  <= LOW_BOUND_RST;
      cfg_q.high_bound <= HIGH_BOUND_RST;
      cfg_q.left_edge  <= LEFT_EDGE_RST;
      cfg_q.right_edge <= RIGHT_EDGE_RST;
      cfg_q.half_width <= HALF_WIDTH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_LOW_BOUND:  cfg_q.low_bound  <= cfg_wdata_i;
        REG_HIGH_BOUND: cfg_q.high_bound <= cfg_wdata_i;
        REG_LEFT_EDGE:  cfg_q.left_edge  <= cfg_wdata_i;
        REG_RIGHT_EDGE: cfg_q.right_edge <= cfg_wdata_i;
        REG_HALF_WIDTH: cfg_q.half_width <= cfg_wdata_i[HW_W-1:0];
        default: ;
      endcase
    end
  end

  // stream counters; cleared once a last word is fully flushed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q     <= '0;
      in_cnt_q  <= '0;
      out_cnt_q <= '0;
      last_q    <= 1'b0;
    end else begin
      if (in_fire) begin
        sum_q    <= new_sum;
        in_cnt_q <= in_cnt_q + 1'b1;
        last_q   <= in_last;
      end
      if (out_fire) begin
        out_cnt_q <= out_cnt_q + 1'b1;
      end
      if (state_q == S_CHECK && !emit_more && last_q) begin
        sum_q     <= '0;
        in_cnt_q  <= '0;
        out_cnt_q <= '0;
        last_q    <= 1'b0;
      end
    end
  end

  // result datapath
  always_ff @(posedge clk_i) begin
    if (state_q == S_ZONE) begin
      h_q      <= zone.h;
      pass_q   <= zone.pass;
      hi_idx_q <= i_s + $signed({{(IDX_W-HW_W){1'b0}}, h_eff});
      lo_idx_q <= i_s - $signed({{(IDX_W-HW_W){1'b0}}, h_eff}) - IDX_W'(1);
    end
    if (state_q == S_RD_LO) begin
      hi_val_q <= hi_val;
    end
    if (state_q == S_DIFF) begin
      neg_q            <= diff[SUM_W-1];
      out_q.out_index  <= POS_W'(out_cnt_q);
      out_q.out_last   <= res_last;
      out_q.smoothed_value <= diff[SAMPLE_W-1:0];
    end
    if (state_q == S_DIV && div_done) begin
      out_q.smoothed_value <= neg_q ? quo_neg[SAMPLE_W-1:0] : quo[SAMPLE_W-1:0];
    end
  end

  assign out_data_o = out_q;

`ifndef NO_ASSERTIONS
  // one word in flight: never taking input while a result is offered
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while a result is pending");

  // results never run ahead of received samples
  a_out_behind_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_cnt_q <= in_cnt_q)
    else $error("output count passed input count");

  // divider only started from the diff step and finishes only while waiting on it
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider done outside of divide wait");

  // the final result of a sequence clears the stream state
  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && out_data_o.out_last |=> ##1 (in_cnt_q == '0 && out_cnt_q == '0))
    else $error("stream state not cleared after last result");
`endif

endmodule

// ===== tb/sv/tapered_box_smoother_tb.sv =====
module tapered_box_smoother_tb;
  import tbs_pkg::*;

  // block parameters, kept equal to the instance below
  localparam int NUM_SAMPLES = 512;
  localparam int MAX_HW      = 32;
  localparam int RESULT_LAG  = MAX_HW + 1;

  // run shaping
  localparam int RANDOM_ITEMS  = 150;
  // settle wait after the queue drains; a word that yields nothing finishes well within it
  localparam int SETTLE_CYCLES = 64;
  // watchdog bound for the whole run, drains included
  localparam int CYCLE_LIMIT   = 200_000;
  localparam int MAX_REPORTS   = 10;

  logic       clk;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  in_word_t   in_data_i;
  logic       out_valid_o;
  logic       out_ready_i;
  out_word_t  out_data_o;
  logic                cfg_we_i;
  logic [CFG_AW-1:0]   cfg_addr_i;
  logic [CFG_DW-1:0]   cfg_wdata_i;

  tapered_box_smoother #(
    .SAMPLES        (NUM_SAMPLES),
    .MAX_HALF_WIDTH (MAX_HW)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Smoother prediction: own copy of the register file, the running sum and the
  // prefix sums of the sequence in flight. Every accepted sample word goes
  // through take_sample(), which queues the result words it releases.
  // ---------------------------------------------------------------------------
  cfg_t             filt_cfg;
  logic [SUM_W-1:0] psum_hist [NUM_SAMPLES];
  logic [SUM_W-1:0] run_sum;
  int               n_in;
  int               n_out;
  out_word_t        expected_smoothed [$];

  int  mismatches;
  int  cycle_count;
  int  burst_left;
  int  stall_left;
  int  ready_pct;
  out_word_t want_word;

  // prefix sum at index j; below zero reads zero, past the last word received
  // (only during a flush) reads the final running sum
  function automatic logic [SUM_W-1:0] prefix_at(input int j);
    if (j < 0) return '0;
    if (j >= n_in) return run_sum;
    return psum_hist[j];
  endfunction

  // smoothed value for index i under the current register settings
  function automatic logic [SAMPLE_W-1:0] smooth_at(input int i);
    int               w, lo, hi, le, re, h, a, b;
    logic [SUM_W-1:0] diff;
    longint           s, mag, q, dv;
    w  = (filt_cfg.half_width > MAX_HW) ? MAX_HW : int'(filt_cfg.half_width);
    lo = int'(filt_cfg.low_bound);
    hi = int'(filt_cfg.high_bound);
    le = int'(filt_cfg.left_edge);
    re = int'(filt_cfg.right_edge);
    h  = 0;
    // zones in priority order, each later one overriding; h = 0 is a plain copy
    if (w > 0) begin
      // left taper
      a = (lo + w > le - 2 * w) ? lo + w : le - 2 * w;
      if (i >= a && i < le) h = (le - i) / 2 + 1;
      // right taper
      b = (re + 2 * w - 1 < hi - w - 1) ? re + 2 * w - 1 : hi - w - 1;
      if (i <= b && i > re) h = (i - re) / 2 + 1;
      // far left
      if (i >= w + 1 && i < le - 2 * w) h = w;
      // far right
      a = (re + 2 * w < hi - w - 1) ? re + 2 * w : hi - w - 1;
      if (i >= a && i < NUM_SAMPLES - w - 1) h = w;
    end
    // sums wrap at 29 bits; the difference is taken back as signed
    diff = prefix_at(i + h) - prefix_at(i - h - 1);
    s    = longint'($signed(diff));
    dv   = 2 * h + 1;
    mag  = (s < 0) ? -s : s;
    q    = (mag + dv / 2) / dv;  // round half away from zero
    if (s < 0) q = -q;
    return q[SAMPLE_W-1:0];
  endfunction

  function automatic void take_sample(input in_word_t w);
    out_word_t r;
    logic      is_last;
    run_sum = run_sum + {{(SUM_W - SAMPLE_W){w.sample_value[SAMPLE_W-1]}}, w.sample_value};
    psum_hist[n_in] = run_sum;
    n_in++;
    // the word that fills the sequence ends it even without its last flag
    is_last = w.sample_last || (n_in >= NUM_SAMPLES);
    while (n_out < n_in && (is_last || n_out + RESULT_LAG < n_in)) begin
      r.smoothed_value = smooth_at(n_out);
      r.out_index      = POS_W'(n_out);
      r.out_last       = is_last && (n_out + 1 == n_in);
      expected_smoothed.push_back(r);
      n_out++;
    end
    if (is_last) begin
      run_sum = '0;
      n_in    = 0;
      n_out   = 0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers. Inputs change on the falling edge; handshakes are judged
  // on the rising edge, where the block's outputs still hold their old values.
  // ---------------------------------------------------------------------------

  // one register per cycle; write enable stays up across a run of writes
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DW-1:0] val);
    @(negedge clk);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk);
    case (idx)
      REG_LOW_BOUND:  filt_cfg.low_bound  = val;
      REG_HIGH_BOUND: filt_cfg.high_bound = val;
      REG_LEFT_EDGE:  filt_cfg.left_edge  = val;
      REG_RIGHT_EDGE: filt_cfg.right_edge = val;
      REG_HALF_WIDTH: filt_cfg.half_width = val[HW_W-1:0];
      default: ;
    endcase
  endtask

  // only called with the block idle
  task automatic program_filter(input logic [CFG_DW-1:0] lo, input logic [CFG_DW-1:0] hi,
                                input logic [CFG_DW-1:0] le, input logic [CFG_DW-1:0] re,
                                input logic [CFG_DW-1:0] hw);
    write_reg(REG_LOW_BOUND, lo);
    write_reg(REG_HIGH_BOUND, hi);
    write_reg(REG_LEFT_EDGE, le);
    write_reg(REG_RIGHT_EDGE, re);
    write_reg(REG_HALF_WIDTH, hw);
    @(negedge clk);
    cfg_we_i <= 1'b0;
  endtask

  // send one sample word; bursts of random length separated by random gaps
  task automatic push_sample(input logic [SAMPLE_W-1:0] value, input logic is_last);
    in_word_t    w;
    int unsigned gap;
    w.sample_value = value;
    w.sample_last  = is_last;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        @(negedge clk);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    // valid stays high from the previous word when there is no gap
    @(negedge clk);
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk); while (!in_ready_o);
    take_sample(w);
  endtask

  // drop valid and hold off until every queued result has come back
  task automatic wait_for_results();
    @(negedge clk);
    in_valid_i <= 1'b0;
    while (expected_smoothed.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return {1'b0, {(SAMPLE_W - 1){1'b1}}};
      1:       return {1'b1, {(SAMPLE_W - 1){1'b0}}};
      2:       return SAMPLE_W'($urandom_range(0, 2048)) - 20'd1024;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // index-like register value, small most of the time, with the extremes mixed in
  function automatic logic [POS_W-1:0] pick_pos(input int unsigned span);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return POS_W'($urandom_range(0, span));
    endcase
  endfunction

  // pause_at < 0 means no mid-sequence pause
  task automatic send_sequence(input int len, input logic mark_last, input int pause_at);
    for (int k = 0; k < len; k++) begin
      if (k == pause_at) wait_for_results();
      push_sample(rand_sample(), mark_last && (k == len - 1));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // reset settings, extreme sample values, all copied through at low indices
  task automatic test_extreme_values();
    logic [SAMPLE_W-1:0] vals [8];
    vals = '{20'h7FFFF, 20'h80000, 20'h00000, 20'h00001,
             20'hFFFFF, 20'h7FFFF, 20'h7FFFF, 20'h80000};
    foreach (vals[k]) push_sample(vals[k], k == 7);
    wait_for_results();
  endtask

  // zero width: edges set so index 1 would be tapered otherwise; one-word sequence too
  task automatic test_bypass();
    program_filter(9'd0, 9'd511, 9'd2, 9'd0, 9'd0);
    push_sample(20'h7FFFF, 1'b1);
    wait_for_results();
    send_sequence(3, 1'b1, -1);
    wait_for_results();
  endtask

  // width 1 with edges at the start: windows reach below index 0 and past the end
  task automatic test_edge_reads();
    program_filter(9'd0, 9'd511, 9'd2, 9'd0, 9'd1);
    send_sequence(6, 1'b1, -1);
    wait_for_results();
  endtask

  // half-width write with upper data bits set and over the limit -> saturates to 32
  task automatic test_width_saturation();
    program_filter(9'd10, 9'd40, 9'd511, 9'd0, 9'h1E3);
    send_sequence(8, 1'b1, -1);
    wait_for_results();
  endtask

  // random settings for most sequences, mostly short sequences so every zone shows up
  task automatic test_random_sequences();
    int                sent;
    int                len;
    logic [CFG_DW-1:0] hw;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 5))
          0:       hw = '0;
          1:       hw = CFG_DW'(MAX_HW);
          2:       hw = CFG_DW'($urandom_range(33, 511));
          default: hw = CFG_DW'($urandom_range(1, 8));
        endcase
        program_filter(pick_pos(30), pick_pos(90), pick_pos(60), pick_pos(60), hw);
      end
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(41, 90) : $urandom_range(1, 40);
      send_sequence(len, 1'b1, ($urandom_range(0, 5) == 0) ? len / 2 : -1);
      wait_for_results();
      sent += len;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stretches of random length, each with its own ready rate,
  // from always ready to fully stalled.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_left = $urandom_range(1, 40);
      case ($urandom_range(0, 3))
        0:       ready_pct = 100;
        1:       ready_pct = 75;
        2:       ready_pct = 30;
        default: ready_pct = 0;
      endcase
    end
    stall_left--;
    out_ready_i <= ($urandom_range(1, 100) <= ready_pct);
  end

  // result checker: each accepted word against the oldest expectation
  always @(posedge clk) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_smoothed.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result word: index %0d value %0d last %0b",
                   out_data_o.out_index, $signed(out_data_o.smoothed_value),
                   out_data_o.out_last);
      end else begin
        want_word = expected_smoothed.pop_front();
        if (out_data_o.smoothed_value !== want_word.smoothed_value ||
            out_data_o.out_index !== want_word.out_index ||
            out_data_o.out_last !== want_word.out_last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: want idx %0d val %0d last %0b, got idx %0d val %0d last %0b",
                     want_word.out_index, $signed(want_word.smoothed_value), want_word.out_last,
                     out_data_o.out_index, $signed(out_data_o.smoothed_value),
                     out_data_o.out_last);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    clk         = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_addr_i  = REG_LOW_BOUND;
    cfg_wdata_i = '0;
    mismatches  = 0;
    cycle_count = 0;
    burst_left  = 0;
    stall_left  = 0;
    ready_pct   = 100;
    filt_cfg.low_bound  = LOW_BOUND_RST;
    filt_cfg.high_bound = HIGH_BOUND_RST;
    filt_cfg.left_edge  = LEFT_EDGE_RST;
    filt_cfg.right_edge = RIGHT_EDGE_RST;
    filt_cfg.half_width = HALF_WIDTH_RST;
    run_sum = '0;
    n_in    = 0;
    n_out   = 0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    test_extreme_values();
    test_bypass();
    test_edge_reads();
    test_width_saturation();
    test_random_sequences();

    // anything still queued was never produced
    mismatches += expected_smoothed.size();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/tbs_pkg.sv
sv/tbs_ram.sv
sv/tbs_div.sv
sv/tbs_zone.sv
sv/tapered_box_smoother.sv
tb/sv/tapered_box_smoother_tb.sv
